>>> rtl/drp_pkg.sv
// drp_pkg: shared types and constants of the directory record parser
// used by drp_front, drp_queue, drp_back and dir_record_parser
// no dependencies
package drp_pkg;

    // fixed record layout
    localparam int          BASE_BLOCK   = 1024;
    localparam int          HEADER_BYTES = 8;
    localparam logic [7:0]  DOT_CHAR     = 8'h2E;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 1;
    localparam logic [0:0]  REG_BLOCK_SIZE_CODE = 1'd0;
    localparam logic [0:0]  REG_DIRECTORY_SIZE  = 1'd1;
    localparam int          CFG_DATA_W          = 32;

    // width of the effective block size code
    localparam int          CODE_W = 3;

    // command queue between parser and result stage
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W      = QPTR_W + 1;

    // record parse phase
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_NAME   = 2'd2
    } drp_phase_t;

    // one emit command: a single name byte, or a pair for a two-byte name
    typedef struct packed {
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  pos;
        logic        last;
        logic        pair;
        logic [7:0]  name_length;
        logic [31:0] inode;
        logic [7:0]  etype;
    } drp_cmd_t;

endpackage

>>> rtl/dir_record_parser.sv
// dir_record_parser: top level of the directory record parser
// instantiates drp_front, drp_queue and drp_back; depends on drp_pkg
//
// channel   dir  fields (lowest bit first)
// s_*       in   tdata: data_byte[7:0]; tuser: first_byte
// m_*       out  tdata: name_byte, name_position, name_length, entry_inode,
//                entry_type; tlast: last_of_name
// cfg_*     in   index 0 block_size_code, index 1 directory_size
//
// one input byte per cycle; a two-byte name yields both results from one queued
// command at the result stage, the second while the next byte enters.
// the parser stalls only when the four-entry command queue is full.
// reset (aresetn low, synchronous) clears parse state and configuration.
// a result waiting on m_tready does not stop input until the queue fills.
module dir_record_parser #(
    parameter int MAX_BLOCK_CODE = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wen,
    input  logic [drp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte[7:0]
    input  logic                              s_tuser,   // first_byte
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // name_byte[7:0], name_position[15:8], name_length[23:16],
    // entry_inode[55:24], entry_type[63:56]
    output logic [63:0]                       m_tdata,
    output logic                              m_tlast    // last_of_name
);
    import drp_pkg::*;

    logic        q_push, q_full, q_pop, q_not_empty;
    drp_cmd_t    q_in_cmd, q_head_cmd;
    logic [7:0]  name_byte, name_position, name_length, entry_type;
    logic [31:0] entry_inode;

    // parser front
    drp_front #(
        .MAX_BLOCK_CODE (MAX_BLOCK_CODE)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_first  (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in_cmd)
    );

    // command queue
    drp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd)
    );

    // result stage
    drp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (q_not_empty),
        .cmd               (q_head_cmd),
        .cmd_pop           (q_pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_name_byte     (name_byte),
        .out_name_position (name_position),
        .out_name_length   (name_length),
        .out_entry_inode   (entry_inode),
        .out_entry_type    (entry_type),
        .out_last          (m_tlast)
    );

    // result packing
    assign m_tdata = {entry_type, entry_inode, name_length, name_position, name_byte};

endmodule

>>> rtl/drp_front.sv
// drp_front: per-byte record parser, holds configuration and parse state
// pushes emit commands into the command queue
// depends on drp_pkg
module drp_front #(
    parameter int MAX_BLOCK_CODE = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [drp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [drp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        in_byte,
    input  logic                              in_first,
    input  logic                              q_full,
    output logic                              q_push,
    output drp_pkg::drp_cmd_t                 q_cmd
);
    import drp_pkg::*;

    localparam int OFS_W = 10 + MAX_BLOCK_CODE;
    localparam int BS_W  = OFS_W + 1;
    localparam int SUM_W = ((OFS_W > 16) ? OFS_W : 16) + 1;

    // configuration
    logic [1:0]  code_reg;
    logic [31:0] dir_size_reg;

    // parse state
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [31:0]      dir_reg, dir_next;
    logic [BS_W-1:0]  nxt_reg, nxt_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [31:0]      inode_reg, inode_next;
    logic [15:0]      rlen_reg, rlen_next;
    logic [7:0]       nlen_reg, nlen_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       held_reg, held_next;
    drp_phase_t       phase_reg, phase_next;

    // shared decode
    logic             accept;
    logic [CODE_W-1:0] ceff;
    logic [BS_W-1:0]  bs;
    logic [OFS_W-1:0] p;
    logic [31:0]      dir_v;
    logic             blk_start;
    drp_phase_t       ph_eff;
    logic [BS_W-1:0]  nxt_eff;
    logic             at_rec, rec_ok, hdr_go, in_hdr, hdr_done, name_go;
    logic             in_name, name_end;
    logic [7:0]       i_hdr;
    logic [OFS_W-1:0] start;
    logic [8:0]       need;
    logic [15:0]      len_eff;
    logic [SUM_W-1:0] rec_end;
    logic [SUM_W-1:0] name_end_ofs;
    logic [8:0]       cnt_inc;
    logic [BS_W-1:0]  p_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;

    // effective block size
    assign ceff = (32'(code_reg) > MAX_BLOCK_CODE) ? CODE_W'(MAX_BLOCK_CODE)
                                                  : CODE_W'(code_reg);
    assign bs   = BS_W'(BASE_BLOCK) << ceff;

    // position of this byte, wrapping on a new scan or a shrunk block
    assign p         = (in_first || BS_W'(ofs_reg) >= bs) ? '0 : ofs_reg;
    assign dir_v     = in_first ? 32'd0 : dir_reg;
    assign blk_start = (p == '0);
    assign ph_eff    = blk_start ? PH_WAIT : phase_reg;
    assign nxt_eff   = blk_start ? '0 : nxt_reg;

    // record start check
    assign at_rec  = (ph_eff == PH_WAIT) && (BS_W'(p) == nxt_eff);
    assign rec_ok  = (dir_v < dir_size_reg) && (BS_W'(p) + BS_W'(HEADER_BYTES) <= bs);
    assign hdr_go  = at_rec && rec_ok;
    assign in_hdr  = (ph_eff == PH_HEADER) || hdr_go;
    assign i_hdr   = hdr_go ? 8'd0 : cnt_reg;
    assign hdr_done = in_hdr && (i_hdr >= 8'(HEADER_BYTES - 1));

    // end of header: record extent and name fit
    assign start        = p - OFS_W'(HEADER_BYTES - 1);
    assign need         = 9'(HEADER_BYTES) + 9'(nlen_reg);
    assign len_eff      = (rlen_reg < 16'(need)) ? 16'(need) : rlen_reg;
    assign rec_end      = SUM_W'(start) + SUM_W'(len_eff);
    assign name_end_ofs = SUM_W'(start) + SUM_W'(need);
    assign name_go      = hdr_done && (rlen_reg != 16'd0) && (inode_reg != 32'd0)
                          && (nlen_reg != 8'd0) && (name_end_ofs <= SUM_W'(bs));

    // name phase
    assign in_name  = (ph_eff == PH_NAME);
    assign cnt_inc  = 9'(cnt_reg) + 9'd1;
    assign name_end = in_name && (cnt_inc >= 9'(nlen_reg));
    assign p_inc    = BS_W'(p) + BS_W'(1);

    // phase next state
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (hdr_done) begin
                phase_next = name_go ? PH_NAME : PH_WAIT;
            end else if (in_hdr) begin
                phase_next = PH_HEADER;
            end else if (in_name) begin
                phase_next = name_end ? PH_WAIT : PH_NAME;
            end else begin
                phase_next = PH_WAIT;
            end
        end
    end

    // field capture, counters and emit commands
    always_comb begin
        ofs_next   = ofs_reg;
        dir_next   = dir_reg;
        nxt_next   = nxt_reg;
        cnt_next   = cnt_reg;
        inode_next = inode_reg;
        rlen_next  = rlen_reg;
        nlen_next  = nlen_reg;
        type_next  = type_reg;
        held_next  = held_reg;
        q_push     = 1'b0;
        q_cmd      = '{byte0: in_byte, byte1: in_byte, pos: cnt_reg,
                       last: (cnt_inc == 9'(nlen_reg)), pair: 1'b0,
                       name_length: nlen_reg, inode: inode_reg, etype: type_reg};
        if (accept) begin
            // offsets
            ofs_next = (p_inc >= bs) ? '0 : OFS_W'(p_inc);
            dir_next = (dir_v != 32'hFFFF_FFFF) ? dir_v + 32'd1 : dir_v;
            nxt_next = nxt_eff;
            if (at_rec && !rec_ok) begin
                nxt_next = bs;
            end

            // header bytes
            if (in_hdr) begin
                if (hdr_go) begin
                    inode_next = 32'd0;
                    rlen_next  = 16'd0;
                end
                case (i_hdr)
                    8'd0: inode_next[7:0]   = in_byte;
                    8'd1: inode_next[15:8]  = in_byte;
                    8'd2: inode_next[23:16] = in_byte;
                    8'd3: inode_next[31:24] = in_byte;
                    8'd4: rlen_next[7:0]    = in_byte;
                    8'd5: rlen_next[15:8]   = in_byte;
                    8'd6: nlen_next         = in_byte;
                    default: type_next      = in_byte;
                endcase
                cnt_next = i_hdr + 8'd1;
                if (hdr_done) begin
                    if (rlen_reg == 16'd0) begin
                        nxt_next = bs;
                    end else begin
                        nxt_next = (rec_end > SUM_W'(bs)) ? bs : BS_W'(rec_end);
                    end
                    if (name_go) begin
                        cnt_next = 8'd0;
                    end
                end
            end else if (in_name) begin
                // name bytes
                cnt_next = 8'(cnt_inc);
                if (nlen_reg == 8'd1) begin
                    q_push = (in_byte != DOT_CHAR);
                end else if (nlen_reg == 8'd2) begin
                    if (cnt_reg == 8'd0) begin
                        held_next = in_byte;
                    end else begin
                        q_push      = !((held_reg == DOT_CHAR) && (in_byte == DOT_CHAR));
                        q_cmd.byte0 = held_reg;
                        q_cmd.pos   = 8'd0;
                        q_cmd.last  = 1'b0;
                        q_cmd.pair  = 1'b1;
                    end
                end else begin
                    q_push = 1'b1;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg     <= 2'd0;
            dir_size_reg <= 32'd0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_BLOCK_SIZE_CODE: code_reg     <= cfg_data[1:0];
                REG_DIRECTORY_SIZE:  dir_size_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg   <= '0;
            dir_reg   <= 32'd0;
            nxt_reg   <= '0;
            cnt_reg   <= 8'd0;
            inode_reg <= 32'd0;
            rlen_reg  <= 16'd0;
            nlen_reg  <= 8'd0;
            type_reg  <= 8'd0;
            held_reg  <= 8'd0;
            phase_reg <= PH_WAIT;
        end else begin
            ofs_reg   <= ofs_next;
            dir_reg   <= dir_next;
            nxt_reg   <= nxt_next;
            cnt_reg   <= cnt_next;
            inode_reg <= inode_next;
            rlen_reg  <= rlen_next;
            nlen_reg  <= nlen_next;
            type_reg  <= type_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
        end
    end

endmodule

>>> rtl/drp_queue.sv
// drp_queue: short command queue between the parser and the result stage
// depends on drp_pkg
module drp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  drp_pkg::drp_cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output drp_pkg::drp_cmd_t  head_cmd
);
    import drp_pkg::*;

    drp_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/drp_back.sv
// drp_back: turns queued emit commands into result items, one per cycle while out_ready allows
// output register with a pending second byte for two-byte names
// depends on drp_pkg
module drp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  drp_pkg::drp_cmd_t  cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_name_byte,
    output logic [7:0]         out_name_position,
    output logic [7:0]         out_name_length,
    output logic [31:0]        out_entry_inode,
    output logic [7:0]         out_entry_type,
    output logic               out_last
);
    import drp_pkg::*;

    logic        valid_reg, valid_next;
    logic        sec_reg, sec_next;
    logic [7:0]  sec_byte_reg, sec_byte_next;
    logic [7:0]  byte_reg, byte_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  nlen_reg, nlen_next;
    logic [31:0] inode_reg, inode_next;
    logic [7:0]  type_reg, type_next;
    logic        last_reg, last_next;
    logic        load_ok;

    assign load_ok = !valid_reg || out_ready;

    // output register load
    always_comb begin
        valid_next    = valid_reg;
        sec_next      = sec_reg;
        sec_byte_next = sec_byte_reg;
        byte_next     = byte_reg;
        pos_next      = pos_reg;
        nlen_next     = nlen_reg;
        inode_next    = inode_reg;
        type_next     = type_reg;
        last_next     = last_reg;
        cmd_pop       = 1'b0;
        if (load_ok) begin
            if (sec_reg) begin
                // second byte of a two-byte name
                valid_next = 1'b1;
                sec_next   = 1'b0;
                byte_next  = sec_byte_reg;
                pos_next   = 8'd1;
                last_next  = 1'b1;
            end else if (cmd_valid) begin
                cmd_pop       = 1'b1;
                valid_next    = 1'b1;
                sec_next      = cmd.pair;
                sec_byte_next = cmd.byte1;
                byte_next     = cmd.byte0;
                pos_next      = cmd.pos;
                last_next     = cmd.last;
                nlen_next     = cmd.name_length;
                inode_next    = cmd.inode;
                type_next     = cmd.etype;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sec_reg   <= sec_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sec_byte_reg <= sec_byte_next;
        byte_reg     <= byte_next;
        pos_reg      <= pos_next;
        nlen_reg     <= nlen_next;
        inode_reg    <= inode_next;
        type_reg     <= type_next;
        last_reg     <= last_next;
    end

    assign out_valid         = valid_reg;
    assign out_name_byte     = byte_reg;
    assign out_name_position = pos_reg;
    assign out_name_length   = nlen_reg;
    assign out_entry_inode   = inode_reg;
    assign out_entry_type    = type_reg;
    assign out_last          = last_reg;

endmodule

>>> tb/dir_record_parser_tb.sv
// dir_record_parser_tb: self-checking bench for the directory record parser
// streams directory bytes in, predicts the name items and compares them
// depends on drp_pkg and dir_record_parser
`timescale 1ns / 1ps

module dir_record_parser_tb;
    import drp_pkg::*;

    localparam int MAX_CODE    = 2;
    localparam int STUCK_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    // one input item: first_byte above data_byte
    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } dir_item_t;

    // one name item, laid out as {m_tlast, m_tdata}
    typedef struct packed {
        logic        last;
        logic [7:0]  etype;
        logic [31:0] inode;
        logic [7:0]  nlen;
        logic [7:0]  pos;
        logic [7:0]  nbyte;
    } name_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;
    logic                  m_tlast;

    dir_item_t  dir_bytes_q[$];
    name_item_t expected_names[$];
    logic [7:0] name_buf[$];

    int  err_cnt       = 0;
    int  stuck_cycles  = 0;
    int  send_idle_pct = 19;
    int  recv_idle_pct = 54;
    int  hold_reqs     = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    bit  s_taken       = 1'b0;
    bit  next_first    = 1'b0;
    int  gen_off       = 0;
    int  pushed        = 0;

    // predictor copy of configuration and parse state
    logic [1:0]  cfg_code     = '0;
    logic [31:0] cfg_dir_size = '0;
    int unsigned blk_off      = 0;
    int unsigned next_rec     = 0;
    int unsigned rec_cnt      = 0;
    logic [31:0] dir_off      = '0;
    logic [31:0] inode_acc    = '0;
    logic [15:0] rec_len      = '0;
    logic [7:0]  name_len     = '0;
    logic [7:0]  etype_r      = '0;
    logic [7:0]  held_byte    = '0;
    drp_phase_t  phase        = PH_WAIT;

    dir_record_parser #(
        .MAX_BLOCK_CODE(MAX_CODE)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // queue one expected name item with the current entry fields
    function automatic void add_name_byte(input logic [7:0] nb, input logic [7:0] pos,
                                          input logic last);
        name_item_t item;
        item.last  = last;
        item.etype = etype_r;
        item.inode = inode_acc;
        item.nlen  = name_len;
        item.pos   = pos;
        item.nbyte = nb;
        expected_names.push_back(item);
    endfunction

    // advance the record parse by one directory byte
    function automatic void parse_dir_byte(input logic [7:0] b, input logic first);
        int unsigned bs, p, i, start, need, len, nxt, code;
        code = (cfg_code > MAX_CODE) ? MAX_CODE : cfg_code;
        bs   = BASE_BLOCK << code;
        if (first) begin
            blk_off = 0;
            dir_off = '0;
        end
        // offset past a shrunk block size starts a new block
        if (blk_off >= bs) blk_off = 0;
        p = blk_off;
        if (p == 0) begin
            phase    = PH_WAIT;
            next_rec = 0;
        end
        // record start, unless past the directory end or the header won't fit
        if (phase == PH_WAIT && p == next_rec) begin
            if (dir_off < cfg_dir_size && p + HEADER_BYTES <= bs) begin
                phase     = PH_HEADER;
                rec_cnt   = 0;
                inode_acc = '0;
                rec_len   = '0;
            end else begin
                next_rec = bs;
            end
        end
        if (phase == PH_HEADER) begin
            i = rec_cnt;
            if (i < 4) inode_acc[8*i +: 8] = b;
            else if (i < 6) rec_len[8*(i-4) +: 8] = b;
            else if (i == 6) name_len = b;
            else etype_r = b;
            rec_cnt = i + 1;
            if (i >= 7) begin
                start = p - 7;
                need  = HEADER_BYTES + name_len;
                len   = rec_len;
                phase = PH_WAIT;
                if (len == 0) begin
                    // zero length skips the rest of the block
                    next_rec = bs;
                end else begin
                    if (len < need) len = need;
                    nxt      = start + len;
                    next_rec = (nxt > bs) ? bs : nxt;
                    if (inode_acc != 0 && name_len != 0 && start + need <= bs) begin
                        phase   = PH_NAME;
                        rec_cnt = 0;
                    end
                end
            end
        end else if (phase == PH_NAME) begin
            i = rec_cnt;
            if (name_len == 1) begin
                if (b != DOT_CHAR) add_name_byte(b, 8'd0, 1'b1);
            end else if (name_len == 2) begin
                // two-byte names come out as a pair, except the parent entry
                if (i == 0) begin
                    held_byte = b;
                end else if (!(held_byte == DOT_CHAR && b == DOT_CHAR)) begin
                    add_name_byte(held_byte, 8'd0, 1'b0);
                    add_name_byte(b, 8'd1, 1'b1);
                end
            end else begin
                add_name_byte(b, i[7:0], (i + 1 == name_len));
            end
            rec_cnt = i + 1;
            if (i + 1 >= name_len) phase = PH_WAIT;
        end
        blk_off = (p + 1 >= bs) ? 0 : p + 1;
        if (dir_off != 32'hFFFF_FFFF) dir_off = dir_off + 1;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            err_cnt++;
        end
    endfunction

    // input driver: holds an item until taken, idles at random
    always @(negedge aclk) begin
        if (s_tvalid && !s_taken) begin
            s_tvalid <= 1'b1;
        end else if (dir_bytes_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata  <= dir_bytes_q[0].data;
            s_tuser  <= dir_bytes_q[0].first;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls plus requested long hold-offs
    always @(negedge aclk) begin
        if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted input items, check accepted name items
    always @(posedge aclk) begin : monitor
        name_item_t got, want;
        bit         m_taken;
        s_taken = s_tvalid && s_tready && aresetn;
        m_taken = m_tvalid && m_tready && aresetn;
        if (s_taken) begin
            parse_dir_byte(dir_bytes_q[0].data, dir_bytes_q[0].first);
            void'(dir_bytes_q.pop_front());
        end
        if (m_taken) begin
            got = {m_tlast, m_tdata};
            if (expected_names.size() == 0) begin
                $display("%0t: unexpected name item, expected none actual %h", $time, got);
                err_cnt++;
            end else begin
                want = expected_names.pop_front();
                check_field("name_byte", want.nbyte, got.nbyte);
                check_field("name_position", want.pos, got.pos);
                check_field("name_length", want.nlen, got.nlen);
                check_field("entry_inode", want.inode, got.inode);
                check_field("entry_type", want.etype, got.etype);
                check_field("last_of_name", want.last, got.last);
            end
        end
        // watchdog on cycles without any progress
        if (s_taken || m_taken || cfg_wen) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        if (idx == REG_BLOCK_SIZE_CODE) cfg_code = val[1:0];
        else cfg_dir_size = val;
    endtask

    // wait until every item is taken and every name item has come out
    task automatic drain();
        while (dir_bytes_q.size() != 0 || expected_names.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic start_scan();
        next_first = 1'b1;
        gen_off    = 0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        dir_bytes_q.push_back({next_first, b});
        next_first = 1'b0;
        gen_off++;
        pushed++;
    endtask

    task automatic pad_to(input int target);
        while (gen_off < target) push_byte(8'($urandom));
    endtask

    // random name, dot-heavy when asked
    task automatic fill_name(input int nl, input bit dotty);
        name_buf.delete();
        for (int k = 0; k < nl; k++)
            name_buf.push_back((dotty && $urandom_range(0, 3) != 0) ? DOT_CHAR :
                               8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_type();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    endfunction

    // one record with the name in name_buf, padded to its length if asked
    task automatic push_rec(input logic [31:0] ino, input int rlen, input bit do_pad);
        int nl;
        nl = name_buf.size();
        for (int k = 0; k < 4; k++) push_byte(ino[8*k +: 8]);
        push_byte(rlen[7:0]);
        push_byte(rlen[15:8]);
        push_byte(nl[7:0]);
        push_byte(pick_type());
        foreach (name_buf[k]) push_byte(name_buf[k]);
        if (do_pad)
            for (int k = HEADER_BYTES + nl; k < rlen; k++) push_byte(8'($urandom));
    endtask

    // a short scan of mostly well-formed records with the odd broken one
    task automatic rand_scan(input int nrec);
        int          kind, sub, need, rlen, nl;
        logic [31:0] ino;
        start_scan();
        for (int r = 0; r < nrec; r++) begin
            kind = $urandom_range(0, 99);
            ino  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
            if (ino == 0) ino = 1;
            if (kind < 6) begin
                ino = '0;
                fill_name($urandom_range(1, 8), 1'b0);
            end else if (kind < 14) fill_name(1, 1'b1);
            else if (kind < 24) fill_name(2, 1'b1);
            else if (kind < 28) fill_name(0, 1'b0);
            else if (kind < 29) fill_name($urandom_range(200, 255), 1'b0);
            else fill_name($urandom_range(3, 12), $urandom_range(0, 5) == 0);
            nl   = name_buf.size();
            need = HEADER_BYTES + nl;
            sub  = $urandom_range(0, 99);
            if (sub < 8) begin
                // zero length: rest of the block is skipped
                push_rec(ino, 0, 1'b0);
                repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
                return;
            end else if (sub < 18) begin
                rlen = $urandom_range(1, need - 1);
                push_rec(ino, rlen, 1'b0);
            end else if (sub < 22) begin
                // length far past the block end, remainder never parsed
                push_rec(ino, $urandom_range(16'hFF00, 16'hFFFF), 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
                return;
            end else begin
                push_rec(ino, need + $urandom_range(0, 6), 1'b1);
            end
        end
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
    endtask

    task automatic add_random(input int n);
        int target;
        target = pushed + n;
        while (pushed < target) begin
            if ($urandom_range(0, 9) == 0) begin
                start_scan();
                repeat ($urandom_range(1, 16)) push_byte(8'($urandom));
            end else begin
                rand_scan($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero directory size: every byte is ignored
        write_reg(REG_BLOCK_SIZE_CODE, 32'd0);
        write_reg(REG_DIRECTORY_SIZE, 32'd0);
        add_random(30);
        drain();

        // directed entries: dot, parent, two-byte pair with extreme bytes
        write_reg(REG_DIRECTORY_SIZE, 32'hFFFF_FFFF);
        start_scan();
        name_buf.delete();
        name_buf.push_back(DOT_CHAR);
        push_rec(32'd1, 9, 1'b1);
        name_buf.push_back(DOT_CHAR);
        push_rec(32'hFFFF_FFFF, 10, 1'b1);
        name_buf.delete();
        name_buf.push_back(8'h00);
        name_buf.push_back(8'hFF);
        push_rec(32'h8000_0000, 10, 1'b1);
        add_random(300);
        // block end: record up to 1020, header crossing, then past-end record
        start_scan();
        fill_name(4, 1'b0);
        push_rec($urandom | 32'd1, 990, 1'b1);
        fill_name(6, 1'b0);
        push_rec($urandom | 32'd1, 30, 1'b1);
        pad_to(1024);
        fill_name(3, 1'b0);
        push_rec($urandom | 32'd1, 2000, 1'b0);
        repeat (5) push_byte(8'($urandom));
        drain();

        // oversized code acts as the largest block, small directory sizes
        send_idle_pct = 54;
        recv_idle_pct = 19;
        write_reg(REG_BLOCK_SIZE_CODE, 32'd3);
        write_reg(REG_DIRECTORY_SIZE, $urandom_range(16, 300));
        add_random(250);
        drain();
        write_reg(REG_BLOCK_SIZE_CODE, 32'd1);
        write_reg(REG_DIRECTORY_SIZE, $urandom_range(40, 400));
        add_random(250);
        drain();

        // no idling, long result hold-off to fill the command queue up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_BLOCK_SIZE_CODE, 32'd2);
        write_reg(REG_DIRECTORY_SIZE, 32'hFFFF_FFFF);
        add_random(250);
        @(posedge aclk);
        hold_reqs++;
        // leave the parse offset past 1024 for the shrink below
        start_scan();
        fill_name(5, 1'b0);
        push_rec($urandom | 32'd1, 1100, 1'b1);
        fill_name(4, 1'b0);
        push_rec($urandom | 32'd1, 12, 1'b1);
        drain();

        // shrink to 1024 mid-block, then a name crossing the block end
        send_idle_pct = 19;
        recv_idle_pct = 54;
        write_reg(REG_BLOCK_SIZE_CODE, 32'd0);
        next_first = 1'b0;
        gen_off    = 0;
        fill_name(3, 1'b0);
        push_rec($urandom | 32'd1, 1010, 1'b1);
        fill_name(10, 1'b0);
        push_rec($urandom | 32'd1, 40, 1'b0);
        add_random(120);
        drain();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
